@@ rtl/core/mes_pkg.sv @@
// Shared types, constants and helpers of the Mandelbrot escape-time shader.
package mes_pkg;

    localparam int VIEW_WIDTH  = 512;
    localparam int QUEUE_DEPTH = 2;   // power of two
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    localparam logic [1:0] REG_X_ORIGIN   = 2'd0;
    localparam logic [1:0] REG_Y_ORIGIN   = 2'd1;
    localparam logic [1:0] REG_PIXEL_STEP = 2'd2;
    localparam logic [1:0] REG_MAX_ITER   = 2'd3;

    localparam logic signed [31:0] RST_X_ORIGIN   = -32'sd33554432;
    localparam logic signed [31:0] RST_Y_ORIGIN   = -32'sd33554432;
    localparam logic [30:0]        RST_PIXEL_STEP = 31'd134218;
    localparam logic [15:0]        RST_MAX_ITER   = 16'd10;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic [7:0]         SHADE_MAX = 8'hFF;

    typedef struct packed {
        logic [8:0] column;
        logic [8:0] row;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] shade;
        logic       escaped;
    } t_pix_out;

    typedef struct packed {
        logic signed [31:0] x_origin;
        logic signed [31:0] y_origin;
        logic [30:0]        pixel_step;
        logic [15:0]        max_iter;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] cre;
        logic signed [31:0] cim;
    } t_coord;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_UPD,
        B_SHADE
    } t_back_state;

    // Saturate a 42-bit signed value to Q8.24.
    function automatic logic signed [31:0] sat_q(input logic signed [41:0] v);
        logic signed [31:0] res;
        if ((v[41:31] == 11'h000) || (v[41:31] == 11'h7FF)) begin
            res = v[31:0];
        end else if (v[41]) begin
            res = Q_MIN;
        end else begin
            res = Q_MAX;
        end
        return res;
    endfunction

endpackage

@@ rtl/core/mes_front.sv @@
// Front end: accepts pixel beats, forms c and pushes it into the queue.
module mes_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mes_pkg::t_cfg   i_cfg,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  mes_pkg::t_pix_in i_pix,
    output logic            o_q_push,
    output mes_pkg::t_coord o_q_data,
    input  logic            i_q_full
);
    import mes_pkg::*;

    localparam int VIEW_MAX = VIEW_WIDTH - 1;

    logic    r_valid;
    t_pix_in r_pix;
    logic    w_push;

    function automatic logic [8:0] clamp_idx(input logic [8:0] idx);
        logic [8:0] res;
        if (32'(idx) > VIEW_MAX) begin
            res = 9'(VIEW_MAX);
        end else begin
            res = idx;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] coord(input logic signed [31:0] origin,
                                                 input logic [8:0] idx,
                                                 input logic [30:0] step);
        logic [39:0]        prod;
        logic signed [41:0] sum;
        prod = 40'(idx) * 40'(step);
        sum  = {{10{origin[31]}}, origin} + signed'({2'b00, prod});
        return sat_q(sum);
    endfunction

    assign w_push     = r_valid && !i_q_full;
    assign o_in_ready = !r_valid || w_push;
    assign o_q_push   = w_push;

    always_comb begin
        o_q_data.cre = coord(i_cfg.x_origin, clamp_idx(r_pix.column), i_cfg.pixel_step);
        o_q_data.cim = coord(i_cfg.y_origin, clamp_idx(r_pix.row), i_cfg.pixel_step);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_valid <= 1'b1;
        end else if (w_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_pix <= i_pix;
        end
    end

endmodule

@@ rtl/core/mes_queue.sv @@
// Short queue of c coordinates between front and back.
module mes_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mes_pkg::t_coord i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output mes_pkg::t_coord o_data
);
    import mes_pkg::*;

    t_coord              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QPTR_W:0]     r_count;

    assign o_full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ rtl/core/mes_back.sv @@
// Back end: iterates z = z*z + c, then shades and holds the result beat.
module mes_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mes_pkg::t_cfg    i_cfg,
    input  logic             i_q_valid,
    input  mes_pkg::t_coord  i_q_data,
    output logic             o_q_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output mes_pkg::t_pix_out o_res
);
    import mes_pkg::*;

    t_back_state        r_state, n_state;
    t_coord             r_c;
    logic signed [31:0] r_re, n_re;
    logic signed [31:0] r_im, n_im;
    logic signed [63:0] r_rr, r_ii, r_ri;
    logic [15:0]        r_n, n_n;
    logic [63:0]        r_mag, n_mag;
    logic               r_out_valid, n_out_valid;
    t_pix_out           r_res, n_res;

    logic [63:0]        w_mag;
    logic signed [63:0] w_diff;
    logic signed [41:0] w_re_sum;
    logic signed [41:0] w_im_sum;
    logic [62:0]        w_scaled;
    logic [14:0]        w_shade;

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

    // |z|^2 of the current z comes from the squares of this iteration.
    assign w_mag    = unsigned'(r_rr) + unsigned'(r_ii);
    assign w_diff   = r_rr - r_ii;
    assign w_re_sum = {{2{w_diff[63]}}, w_diff[63:24]} + {{10{r_c.cre[31]}}, r_c.cre};
    assign w_im_sum = {r_ri[63], r_ri[63:23]} + {{10{r_c.cim[31]}}, r_c.cim};

    // mag * 100 = mag * (64 + 32 + 4)
    assign w_scaled = {r_mag[56:0], 6'b0} + {1'b0, r_mag[56:0], 5'b0}
                    + {4'b0, r_mag[56:0], 2'b0};
    assign w_shade  = w_scaled[62:48];

    always_comb begin
        n_state     = r_state;
        n_re        = r_re;
        n_im        = r_im;
        n_n         = r_n;
        n_mag       = r_mag;
        n_out_valid = r_out_valid && !i_out_ready;
        n_res       = r_res;
        o_q_pop     = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_re    = '0;
                    n_im    = '0;
                    n_n     = '0;
                    n_state = B_MUL;
                end
            end
            B_MUL: begin
                n_state = B_UPD;
            end
            B_UPD: begin
                n_mag = w_mag;
                if ((r_n < i_cfg.max_iter) && (w_mag[63:50] == '0)) begin
                    n_re    = sat_q(w_re_sum);
                    n_im    = sat_q(w_im_sum);
                    n_n     = r_n + 16'd1;
                    n_state = B_MUL;
                end else begin
                    n_state = B_SHADE;
                end
            end
            B_SHADE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid   = 1'b1;
                    n_res.escaped = (r_mag[63:50] != '0);
                    if ((r_mag[63:56] != '0) || (w_shade > 15'd255)) begin
                        n_res.shade = SHADE_MAX;
                    end else begin
                        n_res.shade = w_shade[7:0];
                    end
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_c <= i_q_data;
        end
        r_re  <= n_re;
        r_im  <= n_im;
        r_n   <= n_n;
        r_mag <= n_mag;
        r_res <= n_res;
        r_rr  <= r_re * r_re;
        r_ii  <= r_im * r_im;
        r_ri  <= r_re * r_im;
    end

endmodule

@@ rtl/core/mandelbrot_escape_shader_top.sv @@
// Path: the front registers each pixel and pushes c into the queue, where it may wait; the back
// then loops through MUL and UPD for k iterations (k <= max_iter, stops early on escape) and SHADE.
// Flow: the back takes a new pixel only after it has shaded the last one, set by the squaring loop.
// Reset: config registers take their defaults, queue and result register empty.
// Top level of the Mandelbrot escape-time shader.
module mandelbrot_escape_shader_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mes_pkg::t_pix_in  i_pix,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mes_pkg::t_pix_out o_res
);
    import mes_pkg::*;

    t_cfg   r_cfg;
    logic   w_push;
    t_coord w_push_data;
    logic   w_full;
    logic   w_q_valid;
    t_coord w_q_data;
    logic   w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_origin   <= RST_X_ORIGIN;
            r_cfg.y_origin   <= RST_Y_ORIGIN;
            r_cfg.pixel_step <= RST_PIXEL_STEP;
            r_cfg.max_iter   <= RST_MAX_ITER;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_X_ORIGIN:   r_cfg.x_origin   <= i_cfg_data;
                REG_Y_ORIGIN:   r_cfg.y_origin   <= i_cfg_data;
                REG_PIXEL_STEP: r_cfg.pixel_step <= i_cfg_data[30:0];
                REG_MAX_ITER:   r_cfg.max_iter   <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    mes_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_pix      (i_pix),
        .o_q_push   (w_push),
        .o_q_data   (w_push_data),
        .i_q_full   (w_full)
    );

    mes_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    mes_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_data    (w_q_data),
        .o_q_pop     (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (o_res)
    );

endmodule

@@ rtl/core/mes_checker.sv @@
// Port-level checks of the Mandelbrot escape-time shader, bound to the top level.
module mes_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input mes_pkg::t_pix_out o_res
);
    import mes_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_res))
        else $error("result beat changed while stalled");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat pending after reset");

    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready after reset");

    a_escape_shade: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_res.escaped |-> o_res.shade == SHADE_MAX)
        else $error("escaped point without full shade");

endmodule

bind mandelbrot_escape_shader_top mes_checker u_chk (.*);

@@ tb/mes_result_checker.sv @@
// Checker for the Mandelbrot shader: tracks config, predicts each pixel, compares results.
`timescale 1ns / 100ps

module mes_result_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  mes_pkg::t_pix_in  i_pix,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  mes_pkg::t_pix_out i_res,
    output int                o_fail_count,
    output int                o_pending
);
    import mes_pkg::*;

    localparam logic [63:0] ESC_Q48      = 64'd4 << 48;
    localparam logic [63:0] SHADE_CLIP_Q = 64'd1 << 56;

    logic signed [31:0] view_x0;
    logic signed [31:0] view_y0;
    logic [30:0]        view_step;
    logic [15:0]        iter_cap;

    t_pix_out shade_due[$];
    int       fails = 0;

    function automatic logic signed [31:0] clamp_q(input longint v);
        if (v > longint'(Q_MAX)) begin
            return Q_MAX;
        end else if (v < longint'(Q_MIN)) begin
            return Q_MIN;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] axis_pos(input logic signed [31:0] org,
                                                   input logic [8:0] idx);
        longint pos;
        pos = longint'(idx);
        if (pos > VIEW_WIDTH - 1) begin
            pos = VIEW_WIDTH - 1;
        end
        return clamp_q(longint'(org) + pos * longint'(view_step));
    endfunction

    function automatic t_pix_out shade_pixel(input t_pix_in px);
        logic signed [31:0] cre;
        logic signed [31:0] cim;
        logic signed [31:0] zr;
        logic signed [31:0] zi;
        longint             rr;
        longint             ii;
        longint             ri;
        logic [63:0]        mag;
        logic [63:0]        lvl;
        int unsigned        n;
        t_pix_out           r;
        cre = axis_pos(view_x0, px.column);
        cim = axis_pos(view_y0, px.row);
        zr  = '0;
        zi  = '0;
        mag = '0;
        n   = 0;
        while (n < iter_cap && mag < ESC_Q48) begin
            rr  = longint'(zr) * longint'(zr);
            ii  = longint'(zi) * longint'(zi);
            ri  = longint'(zr) * longint'(zi);
            zr  = clamp_q(((rr - ii) >>> 24) + longint'(cre));
            zi  = clamp_q((ri >>> 23) + longint'(cim));
            rr  = longint'(zr) * longint'(zr);
            ii  = longint'(zi) * longint'(zi);
            mag = 64'(rr) + 64'(ii);
            n++;
        end
        if (mag >= SHADE_CLIP_Q) begin
            r.shade = SHADE_MAX;
        end else begin
            lvl     = (mag * 64'd100) >> 48;
            r.shade = (lvl > 64'd255) ? SHADE_MAX : lvl[7:0];
        end
        r.escaped = (mag >= ESC_Q48);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_pix_out want;
        if (!i_rst_n) begin
            view_x0   = RST_X_ORIGIN;
            view_y0   = RST_Y_ORIGIN;
            view_step = RST_PIXEL_STEP;
            iter_cap  = RST_MAX_ITER;
            shade_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_X_ORIGIN:   view_x0   = i_cfg_data;
                    REG_Y_ORIGIN:   view_y0   = i_cfg_data;
                    REG_PIXEL_STEP: view_step = i_cfg_data[30:0];
                    REG_MAX_ITER:   iter_cap  = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                shade_due.push_back(shade_pixel(i_pix));
            end
            if (i_out_valid && i_out_ready) begin
                if (shade_due.size() == 0) begin
                    $error("result beat with no pixel pending: shade %0d escaped %0d",
                           i_res.shade, i_res.escaped);
                    fails++;
                end else begin
                    want = shade_due.pop_front();
                    if (i_res.shade !== want.shade) begin
                        $error("shade: expected %0d, got %0d", want.shade, i_res.shade);
                        fails++;
                    end
                    if (i_res.escaped !== want.escaped) begin
                        $error("escaped: expected %0d, got %0d", want.escaped, i_res.escaped);
                        fails++;
                    end
                end
            end
        end
        o_pending    <= shade_due.size();
        o_fail_count <= fails;
    end

endmodule

@@ tb/mandelbrot_escape_shader_top_test.sv @@
// Testbench top for the Mandelbrot shader: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module mandelbrot_escape_shader_top_test;
    import mes_pkg::*;

    localparam int RANDOM_PIXELS = 1900;
    localparam int LINGER        = 2 * 64 + 20;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_idx   = REG_X_ORIGIN;
    logic [31:0] i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_pix_in     i_pix       = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_pix_out    o_res;

    int fail_count;
    int pending;
    bit calm = 1'b0;
    int ready_cnt = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    mandelbrot_escape_shader_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_pix       (i_pix),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (o_res)
    );

    mes_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_pix        (i_pix),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_res        (o_res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    always @(negedge i_clk) begin
        if (ready_cnt != 0) begin
            ready_cnt <= ready_cnt - 1;
        end else if (calm || $urandom_range(0, 1) == 0) begin
            i_out_ready <= 1'b1;
            ready_cnt   <= $urandom_range(0, 8);
        end else begin
            i_out_ready <= 1'b0;
            ready_cnt   <= idle_gap();
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    task automatic set_view(input logic [31:0] x0, input logic [31:0] y0,
                            input logic [31:0] stp, input logic [31:0] iters);
        write_reg(REG_X_ORIGIN, x0);
        write_reg(REG_Y_ORIGIN, y0);
        write_reg(REG_PIXEL_STEP, stp);
        write_reg(REG_MAX_ITER, iters);
    endtask

    task automatic send_pixel(input logic [8:0] col, input logic [8:0] row);
        int gap;
        gap = calm ? 0 : idle_gap();
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_pix.column = col;
        i_pix.row    = row;
        i_in_valid   = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic random_view();
        int          kind;
        int          r;
        logic [31:0] x0;
        logic [31:0] y0;
        logic [31:0] stp;
        logic [15:0] iters;
        kind = $urandom_range(0, 9);
        x0   = $urandom_range(0, 32'h0400_0000) - 32'h0300_0000;
        y0   = $urandom_range(0, 32'h0400_0000) - 32'h0280_0000;
        stp  = $urandom_range(32'h400, 32'h4_0000) | ($urandom_range(0, 1) << 31);
        if (kind == 7) begin
            x0  = $urandom();
            y0  = $urandom();
            stp = $urandom();
        end else if (kind == 8) begin
            x0  = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
            y0  = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
            stp = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h7FFF_FFFF;
        end else if (kind == 9) begin
            stp = '0;
        end
        r = $urandom_range(0, 9);
        if (r == 0) begin
            iters = 16'd0;
        end else if (r == 1) begin
            iters = 16'd1;
        end else if (r == 2) begin
            iters = 16'd64;
        end else begin
            iters = 16'($urandom_range(2, 40));
        end
        set_view(x0, y0, stp, {16'($urandom()), iters});
    endtask

    initial begin
        int sent;
        int chunk;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset view: corners, center and one interior point
        calm = 1'b1;
        send_pixel(9'd0, 9'd0);
        send_pixel(9'd511, 9'd511);
        send_pixel(9'd256, 9'd256);
        send_pixel(9'd511, 9'd0);
        send_pixel(9'd0, 9'd511);
        send_pixel(9'd170, 9'd300);
        calm = 1'b0;
        drain();

        // zero and single iteration
        write_reg(REG_MAX_ITER, 32'd0);
        send_pixel(9'd256, 9'd256);
        send_pixel(9'd0, 9'd0);
        drain();
        write_reg(REG_MAX_ITER, 32'hFFFF_0001);
        send_pixel(9'd256, 9'd256);
        send_pixel(9'd3, 9'd400);
        drain();

        // coordinate overflow on both axes
        set_view(Q_MAX, Q_MIN, 32'hFFFF_FFFF, 32'd10);
        send_pixel(9'd511, 9'd511);
        send_pixel(9'd0, 9'd0);
        send_pixel(9'd1, 9'd0);
        drain();
        set_view(Q_MIN, Q_MAX, 32'h7FFF_FFFF, 32'd10);
        send_pixel(9'd511, 9'd511);
        send_pixel(9'd0, 9'd0);
        send_pixel(9'd0, 9'd1);
        drain();

        // origin fixed point at full iteration limit, then a fast escape
        set_view(32'd0, 32'd0, 32'd0, 32'h0000_FFFF);
        send_pixel(9'd511, 9'd511);
        drain();
        write_reg(REG_X_ORIGIN, 32'h0400_0000);
        send_pixel(9'd0, 9'd0);
        drain();

        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            drain();
            random_view();
            calm  = ($urandom_range(0, 4) == 0);
            chunk = $urandom_range(30, 120);
            repeat (chunk) begin
                send_pixel(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
            end
            sent += chunk;
        end

        drain();
        repeat (LINGER) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/mes_pkg.sv
rtl/core/mes_front.sv
rtl/core/mes_queue.sv
rtl/core/mes_back.sv
rtl/core/mandelbrot_escape_shader_top.sv
rtl/core/mes_checker.sv
tb/mes_result_checker.sv
tb/mandelbrot_escape_shader_top_test.sv
